// ===== sv/tlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_pkg
// Constants and codes shared by the fully associative translation buffer.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int ENTRIES    = 8;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;
  localparam int CNT_BITS   = 32;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // rank of the least recently used slot
  localparam logic [IDX_BITS-1:0] RANK_LRU = IDX_BITS'(ENTRIES - 1);

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [IDX_BITS-1:0]   rank_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [ENTRIES-1:0]    slot_vec_t;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

endpackage

// ===== sv/tlb_lru_lookup_insert.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_lookup_insert
// Fully associative translation buffer, LRU replacement, lookup and insert.
// ----------------------------------------------------------------------------
// An item is taken whenever start is high; busy is always low, so one lookup
// or insert can be issued every cycle. Each item gives exactly one result,
// shown for one cycle with out_valid once the item has passed the input
// register and the result register: while the item sits in the input
// register, tag compare, recency update and state write are done and land in
// the result register. The state written by one item is seen by the very next one. The
// receiver cannot stall; results must be taken as they appear. Page and frame
// storage come up undefined; only the valid bits, recency ranks and hit/miss
// counters are reset.
module tlb_lru_lookup_insert (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [tlb_pkg::PAGE_BITS-1:0]  in_page,
  input  logic [tlb_pkg::FRAME_BITS-1:0] in_frame_in,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [tlb_pkg::FRAME_BITS-1:0] out_frame_out,
  output logic                          out_evicted,
  output logic [tlb_pkg::PAGE_BITS-1:0]  out_evicted_page,
  output logic [tlb_pkg::CNT_BITS-1:0]   out_hit_total,
  output logic [tlb_pkg::CNT_BITS-1:0]   out_miss_total
);

  // input register
  logic                  in_vld_r;
  logic                  in_func_r;
  tlb_pkg::page_t        in_page_r;
  tlb_pkg::frame_t       in_frame_r;

  // buffer state
  tlb_pkg::slot_vec_t    valid_r, valid_nxt;
  tlb_pkg::page_t        page_r  [tlb_pkg::ENTRIES];
  tlb_pkg::frame_t       frame_r [tlb_pkg::ENTRIES];
  tlb_pkg::rank_t        rank_r  [tlb_pkg::ENTRIES];
  tlb_pkg::rank_t        rank_nxt[tlb_pkg::ENTRIES];
  tlb_pkg::cnt_t         hit_cnt_r, hit_cnt_nxt;
  tlb_pkg::cnt_t         miss_cnt_r, miss_cnt_nxt;

  // compare and select
  tlb_pkg::slot_vec_t    match_oh;
  tlb_pkg::slot_vec_t    free_oh;
  tlb_pkg::slot_vec_t    lru_oh;
  tlb_pkg::slot_vec_t    sel_oh;
  tlb_pkg::slot_vec_t    wr_oh;
  logic                  any_match;
  logic                  any_free;
  logic                  is_insert;
  logic                  do_touch;
  logic                  do_evict;
  tlb_pkg::rank_t        sel_rank;
  tlb_pkg::frame_t       hit_frame;
  tlb_pkg::page_t        lru_page;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    if (start) begin
      in_func_r  <= in_func;
      in_page_r  <= in_page;
      in_frame_r <= in_frame_in;
    end
  end

  always_comb begin
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      match_oh[i] = valid_r[i] && (page_r[i] == in_page_r);
      lru_oh[i]   = (rank_r[i] == tlb_pkg::RANK_LRU);
    end
    // lowest clear valid bit
    free_oh   = ~valid_r & (valid_r + tlb_pkg::slot_vec_t'(1));
    any_match = |match_oh;
    any_free  = |free_oh;
    is_insert = (in_func_r == tlb_pkg::FUNC_INSERT);

    if (!is_insert || any_match) begin
      sel_oh = match_oh;
    end else if (any_free) begin
      sel_oh = free_oh;
    end else begin
      sel_oh = lru_oh;
    end

    do_touch = in_vld_r && (is_insert || any_match);
    do_evict = is_insert && !any_match && !any_free;
    wr_oh    = (in_vld_r && is_insert) ? sel_oh : '0;

    sel_rank  = '0;
    hit_frame = '0;
    lru_page  = '0;
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      sel_rank  = sel_rank  | (sel_oh[i]   ? rank_r[i]  : '0);
      hit_frame = hit_frame | (match_oh[i] ? frame_r[i] : '0);
      lru_page  = lru_page  | (lru_oh[i]   ? page_r[i]  : '0);
    end

    // selected slot becomes most recent, newer slots age by one
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      if (!do_touch) begin
        rank_nxt[i] = rank_r[i];
      end else if (sel_oh[i]) begin
        rank_nxt[i] = '0;
      end else if (rank_r[i] < sel_rank) begin
        rank_nxt[i] = rank_r[i] + tlb_pkg::rank_t'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end

    valid_nxt    = valid_r | wr_oh;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (in_vld_r && !is_insert) begin
      if (any_match) begin
        hit_cnt_nxt = hit_cnt_r + tlb_pkg::cnt_t'(1);
      end else begin
        miss_cnt_nxt = miss_cnt_r + tlb_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
        rank_r[i] <= tlb_pkg::IDX_BITS'(i);
      end
    end else begin
      valid_r    <= valid_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      if (wr_oh[i]) begin
        page_r[i]  <= in_page_r;
        frame_r[i] <= in_frame_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_vld_r;
    end
    if (in_vld_r) begin
      out_hit          <= !is_insert && any_match;
      out_frame_out    <= (!is_insert && any_match) ? hit_frame : '0;
      out_evicted      <= do_evict;
      out_evicted_page <= do_evict ? lru_page : '0;
      out_hit_total    <= hit_cnt_nxt;
      out_miss_total   <= miss_cnt_nxt;
    end
  end

endmodule

// ===== sim/tlb_lru_lookup_insert_checker.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_lookup_insert_checker
// Watches both channels of the translation buffer, keeps a shadow copy of
// its slots, recency ranks and counters, predicts one result per accepted
// item and compares each strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module tlb_lru_lookup_insert_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_func,
  input  logic [tlb_pkg::PAGE_BITS-1:0]  in_page,
  input  logic [tlb_pkg::FRAME_BITS-1:0] in_frame_in,
  input  logic                           out_valid,
  input  logic                           out_hit,
  input  logic [tlb_pkg::FRAME_BITS-1:0] out_frame_out,
  input  logic                           out_evicted,
  input  logic [tlb_pkg::PAGE_BITS-1:0]  out_evicted_page,
  input  logic [tlb_pkg::CNT_BITS-1:0]   out_hit_total,
  input  logic [tlb_pkg::CNT_BITS-1:0]   out_miss_total,
  output int                             errors,
  output int                             pending,
  output int                             hits_seen,
  output int                             evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            hit;
    tlb_pkg::frame_t frame;
    logic            evicted;
    tlb_pkg::page_t  evicted_page;
    tlb_pkg::cnt_t   hit_total;
    tlb_pkg::cnt_t   miss_total;
  } xlate_result_t;

  logic            slot_valid [tlb_pkg::ENTRIES];
  tlb_pkg::page_t  slot_page  [tlb_pkg::ENTRIES];
  tlb_pkg::frame_t slot_frame [tlb_pkg::ENTRIES];
  tlb_pkg::rank_t  slot_rank  [tlb_pkg::ENTRIES];
  tlb_pkg::cnt_t   hit_cnt;
  tlb_pkg::cnt_t   miss_cnt;

  xlate_result_t expected_q[$];
  int n_accepted;
  int n_results;
  int n_mismatch;
  int n_hits;
  int n_evict;

  assign errors         = n_mismatch;
  assign pending        = n_accepted - n_results;
  assign hits_seen      = n_hits;
  assign evictions_seen = n_evict;

  // slot s becomes most recent; slots newer than it age by one
  task automatic make_recent(input int s);
    tlb_pkg::rank_t old;
    old = slot_rank[s];
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      if (slot_rank[i] < old) slot_rank[i] = slot_rank[i] + 1'b1;
    end
    slot_rank[s] = '0;
  endtask

  task automatic translate(input logic f, input tlb_pkg::page_t pg,
                           input tlb_pkg::frame_t fr, output xlate_result_t r);
    int s;
    s = -1;
    r = '0;
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      if (s < 0 && slot_valid[i] && slot_page[i] == pg) s = i;
    end
    if (f == tlb_pkg::FUNC_LOOKUP) begin
      if (s >= 0) begin
        r.hit   = 1'b1;
        r.frame = slot_frame[s];
        make_recent(s);
        hit_cnt = hit_cnt + 1'b1;
      end else begin
        miss_cnt = miss_cnt + 1'b1;
      end
    end else if (s >= 0) begin
      slot_frame[s] = fr;
      make_recent(s);
    end else begin
      for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
        if (s < 0 && !slot_valid[i]) s = i;
      end
      if (s < 0) begin
        s = 0;
        for (int i = tlb_pkg::ENTRIES - 1; i >= 0; i--) begin
          if (slot_rank[i] == tlb_pkg::RANK_LRU) s = i;
        end
        r.evicted      = 1'b1;
        r.evicted_page = slot_page[s];
      end
      slot_valid[s] = 1'b1;
      slot_page[s]  = pg;
      slot_frame[s] = fr;
      make_recent(s);
    end
    r.hit_total  = hit_cnt;
    r.miss_total = miss_cnt;
  endtask

  task automatic check_field(input string fname,
                             input logic [tlb_pkg::CNT_BITS-1:0] want,
                             input logic [tlb_pkg::CNT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin
    xlate_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_page[i]  = '0;
        slot_frame[i] = '0;
        slot_rank[i]  = tlb_pkg::rank_t'(i);
      end
      hit_cnt    = '0;
      miss_cnt   = '0;
      expected_q.delete();
      n_accepted = 0;
      n_results  = 0;
      n_mismatch = 0;
      n_hits     = 0;
      n_evict    = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result with no item outstanding, expected none, actual hit=%0b",
                   $time, out_hit);
          n_mismatch++;
        end else begin
          want = expected_q.pop_front();
          n_results++;
          check_field("hit", tlb_pkg::CNT_BITS'(want.hit),
                      tlb_pkg::CNT_BITS'(out_hit));
          check_field("frame_out", tlb_pkg::CNT_BITS'(want.frame),
                      tlb_pkg::CNT_BITS'(out_frame_out));
          check_field("evicted", tlb_pkg::CNT_BITS'(want.evicted),
                      tlb_pkg::CNT_BITS'(out_evicted));
          check_field("evicted_page", tlb_pkg::CNT_BITS'(want.evicted_page),
                      tlb_pkg::CNT_BITS'(out_evicted_page));
          check_field("hit_total",    want.hit_total,               out_hit_total);
          check_field("miss_total",   want.miss_total,              out_miss_total);
          if (want.hit) n_hits++;
          if (want.evicted) n_evict++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        translate(in_func, in_page, in_frame_in, want);
        expected_q.push_back(want);
        n_accepted++;
      end
    end
  end

endmodule

// ===== sim/tlb_lru_lookup_insert_test.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_lookup_insert_test
// Drives lookups and inserts into the translation buffer: a directed opening
// over empty, full, update and eviction cases, then random phases over small
// page pools with varying sender gaps. The checker does all comparing.
// ----------------------------------------------------------------------------
module tlb_lru_lookup_insert_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 160;

  logic            clk;
  logic            rst_n       = 1'b0;
  logic            start       = 1'b0;
  logic            in_func     = tlb_pkg::FUNC_LOOKUP;
  tlb_pkg::page_t  in_page     = '0;
  tlb_pkg::frame_t in_frame_in = '0;

  logic            busy;
  logic            out_valid;
  logic            out_hit;
  tlb_pkg::frame_t out_frame_out;
  logic            out_evicted;
  tlb_pkg::page_t  out_evicted_page;
  tlb_pkg::cnt_t   out_hit_total;
  tlb_pkg::cnt_t   out_miss_total;

  int errors;
  int pending;
  int hits_seen;
  int evictions_seen;

  int             items_sent;
  int             gap_pct;
  int             pool_n;
  tlb_pkg::page_t page_pool [16];

  tlb_lru_lookup_insert dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_page          (in_page),
    .in_frame_in      (in_frame_in),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_out    (out_frame_out),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total)
  );

  tlb_lru_lookup_insert_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_page          (in_page),
    .in_frame_in      (in_frame_in),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_out    (out_frame_out),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .errors           (errors),
    .pending          (pending),
    .hits_seen        (hits_seen),
    .evictions_seen   (evictions_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("timeout with %0d results outstanding", pending);
    $display("simulation failed");
    $finish;
  end

  // present one item, hold it until taken, then maybe leave some idle cycles
  task automatic issue(input logic f, input tlb_pkg::page_t pg,
                       input tlb_pkg::frame_t fr);
    start       <= 1'b1;
    in_func     <= f;
    in_page     <= pg;
    in_frame_in <= fr;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_item();
    logic            f;
    tlb_pkg::page_t  pg;
    tlb_pkg::frame_t fr;
    f = ($urandom_range(99) < 40) ? tlb_pkg::FUNC_INSERT : tlb_pkg::FUNC_LOOKUP;
    // mostly a small working set so lookups hit and inserts evict
    if ($urandom_range(99) < 80) pg = page_pool[$urandom_range(pool_n - 1)];
    else pg = tlb_pkg::page_t'($urandom);
    case ($urandom_range(9))
      0:       fr = '0;
      1:       fr = '1;
      default: fr = tlb_pkg::frame_t'($urandom);
    endcase
    if ($urandom_range(99) < 4) page_pool[$urandom_range(15)] = tlb_pkg::page_t'($urandom);
    issue(f, pg, fr);
  endtask

  initial begin
    items_sent = 0;
    gap_pct    = 0;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 16; i++) page_pool[i] = tlb_pkg::page_t'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer, extremes, frame update, fill, eviction
    issue(tlb_pkg::FUNC_LOOKUP, '0, '0);
    issue(tlb_pkg::FUNC_INSERT, '0, '1);
    issue(tlb_pkg::FUNC_INSERT, '1, '0);
    issue(tlb_pkg::FUNC_LOOKUP, '0, '1);
    issue(tlb_pkg::FUNC_LOOKUP, '1, '1);
    issue(tlb_pkg::FUNC_INSERT, '0, 20'h5a5a5);
    issue(tlb_pkg::FUNC_LOOKUP, '0, '0);
    for (int i = 1; i <= 6; i++) begin
      issue(tlb_pkg::FUNC_INSERT, tlb_pkg::page_t'(i), tlb_pkg::frame_t'(20'ha5a50 + i));
    end
    issue(tlb_pkg::FUNC_INSERT, 20'h12345, 20'hfedcb);
    issue(tlb_pkg::FUNC_LOOKUP, '1, '0);
    issue(tlb_pkg::FUNC_LOOKUP, 20'h12345, '0);
    issue(tlb_pkg::FUNC_LOOKUP, tlb_pkg::page_t'(1), '0);
    issue(tlb_pkg::FUNC_INSERT, '1, '1);
    issue(tlb_pkg::FUNC_INSERT, 20'h54321, 20'h0f0f0);
    issue(tlb_pkg::FUNC_LOOKUP, tlb_pkg::page_t'(2), '0);
    issue(tlb_pkg::FUNC_INSERT, tlb_pkg::page_t'(1), '0);
    issue(tlb_pkg::FUNC_LOOKUP, 20'h54321, '1);

    // random phases: sender gap percentage and working set size vary
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  pool_n = 10; end
        1: begin gap_pct = 61; pool_n = 16; end
        2: begin gap_pct = 28; pool_n = 6;  end
        default: begin gap_pct = 0; pool_n = 12; end
      endcase
      repeat (PHASE_ITEMS) random_item();
      if (ph == 0) begin
        // drain completely before going on
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    for (int guard = 0; guard < 200 && pending != 0; guard++) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d lookups and inserts over four gap settings;", items_sent);
    $display("saw %0d lookup hits and %0d evictions", hits_seen, evictions_seen);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
